/* design/adpcm_4bit_encoder_macros.svh */
// Assertion macros shared by the checker.
`ifndef ADPCM_4BIT_ENCODER_MACROS_SVH
`define ADPCM_4BIT_ENCODER_MACROS_SVH

// ante holds -> cons holds in the same cycle, outside reset
`define ADPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle, outside reset
`define ADPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle check that also runs while reset is high
`define ADPCM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* design/adpcm_pkg.sv */
package adpcm_pkg;

  localparam int unsigned IDX_MAX  = 48;
  localparam int unsigned MAG_MAX  = 7;
  localparam int unsigned SIGN_POS = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SAT,
    S_DIV2,
    S_DIV1,
    S_DIV0,
    S_UPD
  } enc_state_t;

  // quantizer control: load the remainder, saturation check, or one divide bit
  typedef struct packed {
    logic       load;
    logic       sat;
    logic       div;
    logic [1:0] shift;
  } quant_ctrl_t;

  function automatic logic [10:0] step_size(input logic [5:0] idx);
    logic [10:0] s;
    case (idx)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
      6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
      6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
      6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
      6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
      6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
      6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
      6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
      6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
      6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
      6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
      6'd42: s = 11'd875;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
      6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

endpackage

/* design/adpcm_quant.sv */
module adpcm_quant
  import adpcm_pkg::*;
(
  input  logic        clk,
  input  quant_ctrl_t ctrl,
  input  logic [17:0] abs_in,
  input  logic [10:0] step,
  output logic [2:0]  mag
);

  logic [17:0] rem;
  logic [17:0] operand;
  logic        ge;
  logic [17:0] rem_sub;

  // one shared compare/subtract against step << shift
  assign operand = {7'd0, step} << ctrl.shift;
  assign ge      = rem >= operand;
  assign rem_sub = rem - operand;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= abs_in;
      mag <= 3'd0;
    end else if (ctrl.sat) begin
      if (ge) begin
        mag <= 3'(MAG_MAX);
      end
    end else if (ctrl.div) begin
      if (ge) begin
        rem <= rem_sub;
        mag <= mag | (3'd1 << ctrl.shift);
      end
    end
  end

endmodule

/* design/adpcm_4bit_encoder.sv */
// 4-bit ADPCM encoder, two samples per transfer.
//
// Input channel (in_valid/in_ready): sample_first and sample_second, unsigned
// 8-bit PCM. Output channel (out_valid/out_ready): code_byte, first code in
// bits 3..0, second in bits 7..4; each code is sign in bit 3, magnitude 2..0.
//
// Each sample runs through six states of a small sequencer: difference against
// the prediction, a saturation check, three restoring compare/subtract steps
// (one magnitude bit each, all on one shared unit), then prediction and step
// index update. out_valid rises at the end of the second sample's update and
// in_ready returns with it.
//
// in_ready is high only while the sequencer is idle. The result sits in an
// output register, so a new item can be taken while it waits; if the receiver
// still stalls when the next item finishes, the sequencer holds before its
// last update until the output register frees up.
//
// Reset (rst, synchronous) clears the prediction and step index to zero,
// drops out_valid and returns the sequencer to idle.
module adpcm_4bit_encoder
  import adpcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] sample_first,
  input  logic [7:0] sample_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] code_byte
);

  enc_state_t  state, state_next;
  logic        half;            // 0: first sample, 1: second sample
  logic [7:0]  samp_lo;
  logic [7:0]  samp_hi;
  logic [15:0] pred;
  logic [5:0]  idx;
  logic [10:0] step;
  logic        diff_neg;
  logic [3:0]  code_lo;

  logic [7:0]  samp_cur;
  logic [15:0] diff;
  logic [15:0] diff_abs;
  quant_ctrl_t qctrl;
  logic [2:0]  mag;
  logic        code_neg;
  logic [14:0] prod;
  logic [11:0] delta;
  logic [6:0]  idx_sum;
  logic [5:0]  idx_new;
  logic        upd_go;
  logic        in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // difference wrapped to 16 bits, and its magnitude
  assign samp_cur = half ? samp_hi : samp_lo;
  assign diff     = {8'd0, samp_cur} - pred;
  assign diff_abs = diff[15] ? 16'(~diff + 16'd1) : diff;

  adpcm_quant u_quant (
    .clk    (clk),
    .ctrl   (qctrl),
    .abs_in ({diff_abs, 2'b00}),
    .step   (step),
    .mag    (mag)
  );

  // a quotient that truncates to zero carries no sign
  assign code_neg = diff_neg && (mag != 3'd0);
  assign prod     = 15'({mag, 1'b1}) * 15'(step);
  assign delta    = prod[14:3];

  // index: -1 for magnitudes 0..3, else +2,+4,+6,+8; clamp to table
  always_comb begin
    if (mag[2]) begin
      idx_sum = 7'(idx) + 7'({mag[1:0], 1'b0}) + 7'd2;
    end else if (idx == 6'd0) begin
      idx_sum = 7'd0;
    end else begin
      idx_sum = 7'(idx) - 7'd1;
    end
    idx_new = (idx_sum > 7'(IDX_MAX)) ? 6'(IDX_MAX) : idx_sum[5:0];
  end

  // the second update needs a free output register
  assign upd_go = !half || !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    qctrl       = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        qctrl.load = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        qctrl.sat   = 1'b1;
        qctrl.shift = 2'd3;
        state_next  = S_DIV2;
      end
      S_DIV2: begin
        qctrl.div   = 1'b1;
        qctrl.shift = 2'd2;
        state_next  = S_DIV1;
      end
      S_DIV1: begin
        qctrl.div   = 1'b1;
        qctrl.shift = 2'd1;
        state_next  = S_DIV0;
      end
      S_DIV0: begin
        qctrl.div   = 1'b1;
        qctrl.shift = 2'd0;
        state_next  = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_next = half ? S_IDLE : S_DIFF;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and prediction state
  always_ff @(posedge clk) begin
    if (rst) begin
      half      <= 1'b0;
      pred      <= 16'd0;
      idx       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      // a finished pair refills the output register in the cycle it drains
      if (state == S_UPD && upd_go && half) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_xfer) begin
        half <= 1'b0;
      end
      if (state == S_UPD && upd_go) begin
        pred <= code_neg ? pred - 16'(delta) : pred + 16'(delta);
        idx  <= idx_new;
        half <= !half;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      samp_lo <= sample_first;
      samp_hi <= sample_second;
    end
    if (state == S_DIFF) begin
      step     <= step_size(idx);
      diff_neg <= diff[15];
    end
    if (state == S_UPD && upd_go) begin
      if (half) begin
        code_byte <= {code_neg, mag, code_lo};
      end else begin
        code_lo <= {code_neg, mag};
      end
    end
  end

endmodule

/* design/adpcm_chk.sv */
`include "adpcm_4bit_encoder_macros.svh"

module adpcm_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] code_byte
);

  // sequencer is busy right after taking an item
  `ADPCM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "in_ready after transfer")

  // a result never appears in the cycle after an input transfer from idle output
  `ADPCM_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready && !out_valid, !out_valid, "result too early")

  // reset leaves the block idle with no result pending
  `ADPCM_ASSERT_ALWAYS(a_reset_idle, $past(rst), in_ready && !out_valid, "not idle after reset")

  // stalled result holds
  `ADPCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_byte), "stalled result changed")

endmodule

bind adpcm_4bit_encoder adpcm_chk u_adpcm_chk (.*);
